// File: src/kpsd_pkg.sv
`timescale 1ns / 1ps

package kpsd_pkg;

	localparam int NUM_DIGITS_DEF = 8;

	localparam int SEG_W   = 8;
	localparam int KEY_W   = 4;
	localparam int WAIT_W  = 16;
	localparam int DWELL_W = 8;
	localparam int LINE_W  = 4;
	localparam int SEL_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 2'd2;

	localparam logic [WAIT_W-1:0]  DEBOUNCE_RST = 16'd10;
	localparam logic [WAIT_W-1:0]  TIMEOUT_RST  = 16'd5000;
	localparam logic [DWELL_W-1:0] DWELL_RST    = 8'd1;

	localparam logic [LINE_W-1:0] LINES_IDLE = 4'hf;
	localparam logic [LINE_W-1:0] LINE_SEL0  = 4'h7;
	localparam logic [LINE_W-1:0] LINE_SEL1  = 4'hb;
	localparam logic [LINE_W-1:0] LINE_SEL2  = 4'hd;
	localparam logic [LINE_W-1:0] LINE_SEL3  = 4'he;

	typedef struct packed {
		logic             key_event;
		logic [KEY_W-1:0] key_value;
	} key_status_t;

	function automatic logic [SEG_W-1:0] seg_code(input logic [KEY_W-1:0] k);
		logic [SEG_W-1:0] s;
		unique case (k)
			4'h0: s = 8'h3f;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5b;
			4'h3: s = 8'h4f;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6d;
			4'h6: s = 8'h7d;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7f;
			4'h9: s = 8'h6f;
			4'ha: s = 8'h77;
			4'hb: s = 8'h7c;
			4'hc: s = 8'h39;
			4'hd: s = 8'h5e;
			4'he: s = 8'h79;
			default: s = 8'h71;
		endcase
		return s;
	endfunction

endpackage

// File: src/kpsd_ifs.sv
`timescale 1ns / 1ps

interface kpsd_in_if;
	logic                         valid;
	logic                         ready;
	logic [kpsd_pkg::LINE_W-1:0] col_lines;
	logic [kpsd_pkg::LINE_W-1:0] row_lines;

	modport source (output valid, col_lines, row_lines, input ready);
	modport sink (input valid, col_lines, row_lines, output ready);
endinterface

interface kpsd_out_if;
	logic                        valid;
	logic                        ready;
	logic [kpsd_pkg::SEL_W-1:0] digit_select;
	logic [kpsd_pkg::SEG_W-1:0] segments;
	logic                        key_event;
	logic [kpsd_pkg::KEY_W-1:0] key_code;

	modport source (output valid, digit_select, segments, key_event, key_code, input ready);
	modport sink (input valid, digit_select, segments, key_event, key_code, output ready);
endinterface

interface kpsd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [kpsd_pkg::CFG_IDX_W-1:0]  index;
	logic [kpsd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/kpsd_key_ctrl.sv
`timescale 1ns / 1ps

module kpsd_key_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [kpsd_pkg::LINE_W-1:0]  col_lines,
	input  logic [kpsd_pkg::LINE_W-1:0]  row_lines,
	input  logic [kpsd_pkg::WAIT_W-1:0]  debounce_ticks,
	input  logic [kpsd_pkg::WAIT_W-1:0]  release_timeout_ticks,
	output kpsd_pkg::key_status_t         status
);

	typedef enum logic [1:0] {PH_IDLE, PH_DEB1, PH_DEB2, PH_REL} phase_t;

	phase_t                       phase_q, phase_d;
	logic [kpsd_pkg::WAIT_W-1:0] wait_q, wait_d, wait_inc;
	logic [kpsd_pkg::KEY_W-1:0]  key_q, key_d;
	logic                         ev;

	assign wait_inc = (wait_q != '1) ? wait_q + 16'd1 : wait_q;

	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		key_d   = key_q;
		ev      = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (col_lines != kpsd_pkg::LINES_IDLE) begin
					phase_d = PH_DEB1;
					wait_d  = '0;
				end
			end
			PH_DEB1: begin
				wait_d = wait_inc;
				if (wait_inc >= debounce_ticks) begin
					wait_d = '0;
					if (col_lines != kpsd_pkg::LINES_IDLE) begin
						case (col_lines)
							kpsd_pkg::LINE_SEL0: key_d = 4'd0;
							kpsd_pkg::LINE_SEL1: key_d = 4'd1;
							kpsd_pkg::LINE_SEL2: key_d = 4'd2;
							kpsd_pkg::LINE_SEL3: key_d = 4'd3;
							default: key_d = key_q;
						endcase
						phase_d = PH_DEB2;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_DEB2: begin
				wait_d = wait_inc;
				if (wait_inc >= debounce_ticks) begin
					wait_d = '0;
					case (row_lines)
						kpsd_pkg::LINE_SEL1: key_d = key_q + 4'd4;
						kpsd_pkg::LINE_SEL2: key_d = key_q + 4'd8;
						kpsd_pkg::LINE_SEL3: key_d = key_q + 4'd12;
						default: key_d = key_q;
					endcase
					if (row_lines == kpsd_pkg::LINES_IDLE) begin
						ev      = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_REL;
					end
				end
			end
			default: begin
				wait_d = wait_inc;
				if (row_lines == kpsd_pkg::LINES_IDLE || wait_inc >= release_timeout_ticks) begin
					ev      = 1'b1;
					wait_d  = '0;
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			key_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			key_q   <= key_d;
		end
	end

	assign status.key_event = ev;
	assign status.key_value = key_d;

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> wait_q == '0)
		else $error("wait count not cleared in idle");

	a_event_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ev |-> (phase_q == PH_DEB2 || phase_q == PH_REL))
		else $error("key event outside debounce or release phase");

	a_press_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_IDLE && col_lines != kpsd_pkg::LINES_IDLE)
		|=> phase_q == PH_DEB1)
		else $error("press in idle did not start debounce");

endmodule

// File: src/kpsd_digit_cell.sv
`timescale 1ns / 1ps

module kpsd_digit_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         shift_en,
	input  logic [kpsd_pkg::SEG_W-1:0]  din,
	output logic [kpsd_pkg::SEG_W-1:0]  dnext,
	output logic [kpsd_pkg::SEG_W-1:0]  dq
);

	logic [kpsd_pkg::SEG_W-1:0] digit_q;

	assign dnext = shift_en ? din : digit_q;
	assign dq    = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			digit_q <= dnext;
		end
	end

endmodule

// File: src/kpsd_scan.sv
`timescale 1ns / 1ps

module kpsd_scan #(
	parameter int NUM_DIGITS = kpsd_pkg::NUM_DIGITS_DEF,
	localparam int SCAN_W = $clog2(NUM_DIGITS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [kpsd_pkg::DWELL_W-1:0] dwell_ticks,
	output logic [SCAN_W-1:0]             scan_index
);

	localparam logic [SCAN_W-1:0] LAST = SCAN_W'(NUM_DIGITS - 1);

	logic [kpsd_pkg::DWELL_W-1:0] dwell_q, dwell_inc;
	logic [SCAN_W-1:0]             scan_q;

	assign dwell_inc  = dwell_q + 8'd1;
	assign scan_index = scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= '0;
			scan_q  <= '0;
		end else if (step) begin
			if (dwell_inc >= dwell_ticks || dwell_inc == '0) begin
				dwell_q <= '0;
				scan_q  <= (scan_q == LAST) ? '0 : scan_q + SCAN_W'(1);
			end else begin
				dwell_q <= dwell_inc;
			end
		end
	end

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= LAST)
		else $error("scan index out of range");

endmodule

// File: src/keypad_to_shifting_seven_segment_top.sv
`timescale 1ns / 1ps

// 4x4 keypad scanner with a multiplexed seven-segment display of NUM_DIGITS
// digits. Every input word is one tick and yields exactly one output word,
// in the cycle after, through the output register; a new word is taken every
// clock unless the output word is stalled. A key walks idle, debounce,
// debounce, release wait; its code enters digit 0 of a row of digit cells
// that shift toward the last digit, and shows on the same word. Registers:
// 0 debounce ticks, 1 release timeout ticks, 2 dwell ticks per digit;
// write them only while no word is in flight. digit_select is the scan
// index truncated or zero-extended to 3 bits.
module keypad_to_shifting_seven_segment_top #(
	parameter int NUM_DIGITS = kpsd_pkg::NUM_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kpsd_in_if.sink    in_ch,
	kpsd_out_if.source out_ch,
	kpsd_cfg_if.sink   cfg
);

	localparam int SCAN_W = $clog2(NUM_DIGITS);

	logic [kpsd_pkg::WAIT_W-1:0]  debounce_q, timeout_q;
	logic [kpsd_pkg::DWELL_W-1:0] dwell_q;

	logic                         in_acc, shift_en;
	kpsd_pkg::key_status_t        status;
	logic [SCAN_W-1:0]            scan_index;
	logic [kpsd_pkg::SEG_W-1:0]  seg_next [NUM_DIGITS];
	logic [kpsd_pkg::SEG_W-1:0]  seg_q    [NUM_DIGITS];

	logic                         out_valid_q;
	logic [kpsd_pkg::SEL_W-1:0]  sel_q;
	logic [kpsd_pkg::SEG_W-1:0]  segs_q;
	logic                         event_q;
	logic [kpsd_pkg::KEY_W-1:0]  code_q;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign shift_en    = in_acc && status.key_event;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kpsd_pkg::DEBOUNCE_RST;
			timeout_q  <= kpsd_pkg::TIMEOUT_RST;
			dwell_q    <= kpsd_pkg::DWELL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				kpsd_pkg::REG_DEBOUNCE: debounce_q <= cfg.data;
				kpsd_pkg::REG_TIMEOUT:  timeout_q  <= cfg.data;
				kpsd_pkg::REG_DWELL:    dwell_q    <= cfg.data[kpsd_pkg::DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	kpsd_key_ctrl u_key_ctrl (
		.clk                   (clk),
		.arst_n                (arst_n),
		.step                  (in_acc),
		.col_lines             (in_ch.col_lines),
		.row_lines             (in_ch.row_lines),
		.debounce_ticks        (debounce_q),
		.release_timeout_ticks (timeout_q),
		.status                (status)
	);

	kpsd_scan #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (in_acc),
		.dwell_ticks (dwell_q),
		.scan_index  (scan_index)
	);

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic [kpsd_pkg::SEG_W-1:0] din;
		if (i == 0) begin : g_head
			assign din = kpsd_pkg::seg_code(status.key_value);
		end else begin : g_link
			assign din = seg_q[i-1];
		end
		kpsd_digit_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.din      (din),
			.dnext    (seg_next[i]),
			.dq       (seg_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sel_q   <= kpsd_pkg::SEL_W'(scan_index);
			segs_q  <= seg_next[scan_index];
			event_q <= status.key_event;
			code_q  <= status.key_value;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.digit_select = sel_q;
	assign out_ch.segments     = segs_q;
	assign out_ch.key_event    = event_q;
	assign out_ch.key_code     = code_q;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !in_ch.ready)
		else $error("input taken while output word stalled");

	a_head_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |=> seg_q[0] == kpsd_pkg::seg_code($past(status.key_value)))
		else $error("first digit not loaded with key code");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int DIGITS      = kpsd_pkg::NUM_DIGITS_DEF;
	localparam int STALL_LIMIT = 2000;

	typedef enum logic [1:0] {
		KP_IDLE,
		KP_COL_DEBOUNCE,
		KP_ROW_DEBOUNCE,
		KP_RELEASE_WAIT
	} keypad_phase_t;

	typedef struct packed {
		logic [kpsd_pkg::SEL_W-1:0] digit_select;
		logic [kpsd_pkg::SEG_W-1:0] segments;
		logic                       key_event;
		logic [kpsd_pkg::KEY_W-1:0] key_code;
	} display_word_t;

	logic clk;
	logic arst_n;

	kpsd_in_if  in_ch ();
	kpsd_out_if out_ch ();
	kpsd_cfg_if cfg_ch ();

	keypad_to_shifting_seven_segment_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	logic [kpsd_pkg::SEG_W-1:0] seg_font [16] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
		8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
	};
	logic [kpsd_pkg::LINE_W-1:0] select_codes [4] = '{kpsd_pkg::LINE_SEL0,
		kpsd_pkg::LINE_SEL1, kpsd_pkg::LINE_SEL2, kpsd_pkg::LINE_SEL3};

	// scanner model state
	logic [kpsd_pkg::WAIT_W-1:0]  cfg_debounce;
	logic [kpsd_pkg::WAIT_W-1:0]  cfg_timeout;
	logic [kpsd_pkg::DWELL_W-1:0] cfg_dwell;
	keypad_phase_t                kp_phase;
	logic [kpsd_pkg::WAIT_W-1:0]  kp_wait;
	logic [kpsd_pkg::KEY_W-1:0]   kp_key;
	logic [kpsd_pkg::SEG_W-1:0]   digit_cells [DIGITS];
	int                           scan_pos;
	logic [kpsd_pkg::DWELL_W-1:0] dwell_cnt;

	display_word_t display_expect [$];
	display_word_t want;

	int src_idle;
	int sink_idle;
	int errors;
	int words_sent;
	int words_checked;
	int keys_shifted;
	int reg_writes;
	int stall_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [kpsd_pkg::WAIT_W-1:0] sat_inc(
			input logic [kpsd_pkg::WAIT_W-1:0] c);
		return (c == {kpsd_pkg::WAIT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	function automatic display_word_t predict_tick(input logic [kpsd_pkg::LINE_W-1:0] col,
			input logic [kpsd_pkg::LINE_W-1:0] row);
		display_word_t r;
		logic shift;
		shift = 1'b0;
		case (kp_phase)
			KP_IDLE: begin
				if (col != kpsd_pkg::LINES_IDLE) begin
					kp_phase = KP_COL_DEBOUNCE;
					kp_wait  = '0;
				end
			end
			KP_COL_DEBOUNCE: begin
				kp_wait = sat_inc(kp_wait);
				if (kp_wait >= cfg_debounce) begin
					kp_wait = '0;
					if (col != kpsd_pkg::LINES_IDLE) begin
						case (col)
							kpsd_pkg::LINE_SEL0: kp_key = 4'd0;
							kpsd_pkg::LINE_SEL1: kp_key = 4'd1;
							kpsd_pkg::LINE_SEL2: kp_key = 4'd2;
							kpsd_pkg::LINE_SEL3: kp_key = 4'd3;
							default: ;
						endcase
						kp_phase = KP_ROW_DEBOUNCE;
					end else begin
						kp_phase = KP_IDLE;
					end
				end
			end
			KP_ROW_DEBOUNCE: begin
				kp_wait = sat_inc(kp_wait);
				if (kp_wait >= cfg_debounce) begin
					kp_wait = '0;
					case (row)
						kpsd_pkg::LINE_SEL1: kp_key = kp_key + 4'd4;
						kpsd_pkg::LINE_SEL2: kp_key = kp_key + 4'd8;
						kpsd_pkg::LINE_SEL3: kp_key = kp_key + 4'd12;
						default: ;
					endcase
					if (row == kpsd_pkg::LINES_IDLE) begin
						shift    = 1'b1;
						kp_phase = KP_IDLE;
					end else begin
						kp_phase = KP_RELEASE_WAIT;
					end
				end
			end
			default: begin
				kp_wait = sat_inc(kp_wait);
				if (row == kpsd_pkg::LINES_IDLE || kp_wait >= cfg_timeout) begin
					shift    = 1'b1;
					kp_wait  = '0;
					kp_phase = KP_IDLE;
				end
			end
		endcase

		if (shift) begin
			for (int i = DIGITS - 1; i > 0; i--)
				digit_cells[i] = digit_cells[i-1];
			digit_cells[0] = seg_font[kp_key];
		end

		r.digit_select = kpsd_pkg::SEL_W'(scan_pos);
		r.segments     = digit_cells[scan_pos];
		r.key_event    = shift;
		r.key_code     = kp_key;

		dwell_cnt = dwell_cnt + 1'b1;
		if (dwell_cnt >= cfg_dwell || dwell_cnt == '0) begin
			dwell_cnt = '0;
			scan_pos  = (scan_pos + 1) % DIGITS;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		errors++;
		$display("MISMATCH word %0d %s: got 0x%0h, expected 0x%0h",
			words_checked, what, got, exp_val);
	endtask

	task automatic send_word(input logic [kpsd_pkg::LINE_W-1:0] col,
			input logic [kpsd_pkg::LINE_W-1:0] row);
		while ($urandom_range(0, 99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.col_lines <= col;
		in_ch.row_lines <= row;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		display_expect.push_back(predict_tick(col, row));
		words_sent++;
	endtask

	task automatic wait_display_drained();
		in_ch.valid <= 1'b0;
		while (display_expect.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kpsd_pkg::CFG_IDX_W-1:0] idx,
			input logic [kpsd_pkg::CFG_DATA_W-1:0] value);
		wait_display_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			kpsd_pkg::REG_DEBOUNCE: cfg_debounce = value;
			kpsd_pkg::REG_TIMEOUT:  cfg_timeout  = value;
			kpsd_pkg::REG_DWELL:    cfg_dwell    = value[kpsd_pkg::DWELL_W-1:0];
			default: ;
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input int debounce, input int timeout, input int dwell);
		write_reg(kpsd_pkg::REG_DEBOUNCE, kpsd_pkg::CFG_DATA_W'(debounce));
		write_reg(kpsd_pkg::REG_TIMEOUT, kpsd_pkg::CFG_DATA_W'(timeout));
		write_reg(kpsd_pkg::REG_DWELL, kpsd_pkg::CFG_DATA_W'(dwell));
	endtask

	function automatic logic [kpsd_pkg::LINE_W-1:0] pick_line();
		case ($urandom_range(0, 9))
			0: return kpsd_pkg::LINE_W'($urandom_range(0, 15));
			1: return kpsd_pkg::LINES_IDLE;
			default: return select_codes[$urandom_range(0, 3)];
		endcase
	endfunction

	task automatic send_keystroke();
		logic [kpsd_pkg::LINE_W-1:0] col;
		logic [kpsd_pkg::LINE_W-1:0] row;
		int deb;
		int hold;
		col  = pick_line();
		row  = pick_line();
		deb  = (cfg_debounce == '0) ? 1 : int'(cfg_debounce);
		hold = deb + 1;
		if ($urandom_range(0, 9) == 0)
			hold = $urandom_range(1, hold);
		repeat ($urandom_range(0, 2)) send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
		repeat (hold) send_word(col, kpsd_pkg::LINES_IDLE);
		repeat (deb) send_word(col, row);
		repeat ($urandom_range(0, int'(cfg_timeout) + 2)) send_word(col, row);
		send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_word(kpsd_pkg::LINE_W'($urandom_range(0, 15)),
				kpsd_pkg::LINE_W'($urandom_range(0, 15)));
	endtask

	task automatic test_key_decode();
		set_timing(1, 2, 1);
		// release on the row debounce tick, key 0
		send_word(kpsd_pkg::LINE_SEL0, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL0, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
		// release in wait, key 5
		send_word(kpsd_pkg::LINE_SEL1, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL1, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL1, kpsd_pkg::LINE_SEL1);
		send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
		// hold until timeout, key 10
		send_word(kpsd_pkg::LINE_SEL2, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL2, kpsd_pkg::LINES_IDLE);
		repeat (3) send_word(kpsd_pkg::LINE_SEL2, kpsd_pkg::LINE_SEL2);
		// key 15
		send_word(kpsd_pkg::LINE_SEL3, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL3, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL3, kpsd_pkg::LINE_SEL3);
		send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
		// unmatched column keeps 15, row offset wraps
		send_word(4'h0, kpsd_pkg::LINES_IDLE);
		send_word(4'h0, kpsd_pkg::LINES_IDLE);
		send_word(4'h0, kpsd_pkg::LINE_SEL1);
		send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
		// unmatched row adds nothing
		send_word(kpsd_pkg::LINE_SEL0, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL0, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL0, 4'h0);
		send_word(kpsd_pkg::LINE_SEL0, kpsd_pkg::LINES_IDLE);
		// drop a bounce
		send_word(kpsd_pkg::LINE_SEL0, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
	endtask

	task automatic test_zero_registers();
		set_timing(0, 0, 0);
		send_word(kpsd_pkg::LINE_SEL3, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL3, kpsd_pkg::LINES_IDLE);
		send_word(kpsd_pkg::LINE_SEL3, kpsd_pkg::LINE_SEL1);
		send_word(kpsd_pkg::LINE_SEL3, kpsd_pkg::LINE_SEL1);
		send_word(kpsd_pkg::LINES_IDLE, kpsd_pkg::LINES_IDLE);
	endtask

	task automatic test_register_extremes();
		set_timing(16'hffff, 16'hffff, 8'hff);
		repeat (12) send_word(kpsd_pkg::LINE_SEL1, kpsd_pkg::LINE_SEL2);
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct,
			input int n_words);
		int seg_end;
		src_idle  = src_pct;
		sink_idle = sink_pct;
		for (int s = 0; s < 3; s++) begin
			set_timing($urandom_range(1, 6), $urandom_range(1, 24),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4));
			seg_end = words_sent + n_words / 3;
			while (words_sent < seg_end) begin
				if ($urandom_range(0, 6) == 0)
					send_noise();
				else
					send_keystroke();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (display_expect.size() == 0) begin
				report_mismatch("word with nothing expected", out_ch.segments, 0);
			end else begin
				want = display_expect.pop_front();
				if (out_ch.digit_select !== want.digit_select)
					report_mismatch("digit_select", out_ch.digit_select, want.digit_select);
				if (out_ch.segments !== want.segments)
					report_mismatch("segments", out_ch.segments, want.segments);
				if (out_ch.key_event !== want.key_event)
					report_mismatch("key_event", out_ch.key_event, want.key_event);
				if (out_ch.key_code !== want.key_code)
					report_mismatch("key_code", out_ch.key_code, want.key_code);
				if (want.key_event)
					keys_shifted++;
			end
			words_checked++;
		end
		out_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.col_lines = kpsd_pkg::LINES_IDLE;
		in_ch.row_lines = kpsd_pkg::LINES_IDLE;
		out_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = kpsd_pkg::REG_DEBOUNCE;
		cfg_ch.data     = '0;
		errors          = 0;
		words_sent      = 0;
		words_checked   = 0;
		keys_shifted    = 0;
		reg_writes      = 0;
		cfg_debounce    = kpsd_pkg::DEBOUNCE_RST;
		cfg_timeout     = kpsd_pkg::TIMEOUT_RST;
		cfg_dwell       = kpsd_pkg::DWELL_RST;
		kp_phase        = KP_IDLE;
		kp_wait         = '0;
		kp_key          = '0;
		scan_pos        = 0;
		dwell_cnt       = '0;
		for (int i = 0; i < DIGITS; i++)
			digit_cells[i] = '0;
		src_idle  = 15;
		sink_idle = 79;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_key_decode();
		test_zero_registers();
		test_register_extremes();
		test_random_traffic(15, 79, 345);
		test_random_traffic(79, 15, 345);
		test_random_traffic(0, 0, 345);

		wait_display_drained();
		repeat (4) @(posedge clk);

		$display("Run covered %0d keypad ticks, %0d display words checked,", words_sent,
			words_checked);
		$display("%0d key codes shifted in and %0d register writes", keys_shifted, reg_writes);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
src/kpsd_pkg.sv
src/kpsd_ifs.sv
src/kpsd_key_ctrl.sv
src/kpsd_digit_cell.sv
src/kpsd_scan.sv
src/keypad_to_shifting_seven_segment_top.sv
sim/tb_top.sv
